[sv/fpd_pkg.sv]
// Shared types and constants for the framed packet deframer.
package fpd_pkg;

	localparam int HdrBytes  = 16;
	localparam int HdrIdxW   = 4;
	localparam int FillW     = 5;
	localparam int CfgIdxW   = 3;
	localparam int CfgDataW  = 16;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_SYNC_FIRST   = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_SYNC_SECOND  = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_PROTO_VER    = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_FLAG_MASK    = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_MAX_LEN      = 3'd4;

	typedef enum logic [2:0] {
		EV_STORED   = 3'd0,
		EV_REJECT   = 3'd1,
		EV_TOO_LONG = 3'd2,
		EV_ACCEPT   = 3'd3,
		EV_PAYLOAD  = 3'd4
	} fpd_event_t;

	typedef struct packed {
		logic [7:0]  sync_first;
		logic [7:0]  sync_second;
		logic [7:0]  proto_ver;
		logic [7:0]  allowed_flag_mask;
		logic [15:0] max_body_len;
	} fpd_cfg_t;

	typedef struct packed {
		fpd_event_t  event_res;
		logic [7:0]  msg_type;
		logic [7:0]  frame_flags;
		logic [15:0] body_len;
		logic [31:0] txn_id;
		logic [31:0] seq_num;
		logic [7:0]  payload_byte;
		logic [15:0] payload_index;
		logic        frame_end;
		logic [31:0] error_count;
	} fpd_result_t;

endpackage

[sv/fpd_core.sv]
// Deframer state: header store, frame counters, error total and per-byte result.
module fpd_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fpd_pkg::fpd_cfg_t     cfg,
	input  logic                  fire,
	input  logic [7:0]            rx_byte_s1,
	output fpd_pkg::fpd_result_t  result
);

	logic [7:0]                  hdr_q [fpd_pkg::HdrBytes];
	logic [7:0]                  hdr_new [fpd_pkg::HdrBytes];
	logic [fpd_pkg::FillW-1:0]   fill_q, fill_d, fill_inc;
	logic [15:0]                 seen_q, seen_d, seen_inc;
	logic [15:0]                 expected_q, expected_d;
	logic [31:0]                 err_q, err_d;
	logic                        in_header, hdr_done, hdr_bad, too_long, pay_last;
	logic                        decoded, end_flag;
	logic [15:0]                 len;
	fpd_pkg::fpd_event_t         ev;
	logic [7:0]                  pbyte;
	logic [15:0]                 pidx;

	assign in_header = !fill_q[fpd_pkg::FillW-1];
	assign fill_inc  = fill_q + fpd_pkg::FillW'(1);
	assign seen_inc  = seen_q + 16'd1;
	assign pay_last  = (seen_inc == expected_q);

	// header with the incoming byte already placed
	always_comb begin
		hdr_new = hdr_q;
		if (in_header) begin
			hdr_new[fill_q[fpd_pkg::HdrIdxW-1:0]] = rx_byte_s1;
		end
	end

	assign len      = {hdr_new[7], hdr_new[6]};
	assign too_long = (len > cfg.max_body_len);
	assign hdr_done = in_header && (fill_inc == fpd_pkg::FillW'(fpd_pkg::HdrBytes));
	assign hdr_bad  = (hdr_new[0] != cfg.sync_first) || (hdr_new[1] != cfg.sync_second) ||
	                  (hdr_new[2] != cfg.proto_ver) ||
	                  (hdr_new[5] != 8'(fpd_pkg::HdrBytes)) ||
	                  ((hdr_new[4] & ~cfg.allowed_flag_mask) != 8'd0);

	always_comb begin
		fill_d     = fill_q;
		seen_d     = seen_q;
		expected_d = expected_q;
		err_d      = err_q;
		ev         = fpd_pkg::EV_STORED;
		decoded    = 1'b0;
		end_flag   = 1'b0;
		pbyte      = 8'd0;
		pidx       = 16'd0;
		if (in_header) begin
			fill_d = fill_inc;
			if (hdr_done) begin
				if (hdr_bad) begin
					err_d  = err_q + 32'd1;
					// a leading sync byte is kept as the next header's first byte
					fill_d = (hdr_new[0] == cfg.sync_first) ? fpd_pkg::FillW'(1) : '0;
					ev     = fpd_pkg::EV_REJECT;
				end else begin
					decoded = 1'b1;
					if (too_long) begin
						err_d      = err_q + 32'd1;
						fill_d     = '0;
						seen_d     = '0;
						expected_d = '0;
						ev         = fpd_pkg::EV_TOO_LONG;
					end else begin
						ev         = fpd_pkg::EV_ACCEPT;
						expected_d = len;
						seen_d     = '0;
						if (len == 16'd0) begin
							end_flag   = 1'b1;
							fill_d     = '0;
							expected_d = '0;
						end
					end
				end
			end
		end else begin
			ev      = fpd_pkg::EV_PAYLOAD;
			decoded = 1'b1;
			pbyte   = rx_byte_s1;
			pidx    = seen_q;
			seen_d  = seen_inc;
			if (pay_last) begin
				end_flag   = 1'b1;
				fill_d     = '0;
				seen_d     = '0;
				expected_d = '0;
			end
		end
	end

	always_comb begin
		result.event_res     = ev;
		result.msg_type      = decoded ? hdr_new[3] : 8'd0;
		result.frame_flags   = decoded ? hdr_new[4] : 8'd0;
		result.body_len      = decoded ? len : 16'd0;
		result.txn_id        = decoded ? {hdr_new[11], hdr_new[10], hdr_new[9], hdr_new[8]}
		                               : 32'd0;
		result.seq_num       = decoded ? {hdr_new[15], hdr_new[14], hdr_new[13], hdr_new[12]}
		                               : 32'd0;
		result.payload_byte  = pbyte;
		result.payload_index = pidx;
		result.frame_end     = end_flag;
		result.error_count   = err_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			seen_q     <= '0;
			expected_q <= '0;
			err_q      <= '0;
		end else if (fire) begin
			fill_q     <= fill_d;
			seen_q     <= seen_d;
			expected_q <= expected_d;
			err_q      <= err_d;
		end
	end

	// header bytes: data storage, no reset
	always_ff @(posedge clk) begin
		if (fire && in_header) begin
			hdr_q[fill_q[fpd_pkg::HdrIdxW-1:0]] <= rx_byte_s1;
		end
	end

endmodule

[sv/fpd_out_reg.sv]
// Result register with valid/stall handshake toward the consumer.
module fpd_out_reg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load_valid,
	input  fpd_pkg::fpd_result_t  load_data,
	output logic                  load_ready,
	output logic                  out_valid,
	input  logic                  out_stall,
	output fpd_pkg::fpd_result_t  out_data
);

	logic                 valid_q;
	fpd_pkg::fpd_result_t data_q;

	assign load_ready = !valid_q || !out_stall;
	assign out_valid  = valid_q;
	assign out_data   = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_ready) begin
			valid_q <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ready && load_valid) begin
			data_q <= load_data;
		end
	end

endmodule

[sv/framed_packet_deframer_top.sv]
// Framed packet deframer: top level with config registers, input register and result register.
//
// Takes one received byte per input transaction and returns exactly one result
// transaction per byte. Bytes 0..15 of a frame form the header: while it
// fills, each byte reports "header byte stored"; the sixteenth byte reports
// rejected (sync, version, header-length or flag check failed), length too
// large, or accepted, together with the decoded little-endian length,
// transaction id and sequence. Payload bytes then stream straight through
// with their index, and the last one carries frame_end; a zero-length frame
// ends on the accept itself. A rejected header whose first byte matched
// sync_first keeps that byte as the start of the next header. error_count is
// a wrapping 32-bit total. While out_stall is low, throughput is one byte per clock with no bubbles:
// the byte sits in an input register, a single pass of compares and counter
// updates produces the result, and a result register drives the output.
// The byte is registered in the input register and its result in the result register;
// the result transaction completes when out_valid is high and out_stall is low. Stall on
// the output backs up through the result register to in_stall in the same cycle.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at the
// next edge and must only occur while no transaction is in flight; indexes
// beyond the last register are ignored.
module framed_packet_deframer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [fpd_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [fpd_pkg::CfgDataW-1:0]  cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    rx_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    event_res,
	output logic [7:0]                    msg_type,
	output logic [7:0]                    frame_flags,
	output logic [15:0]                   body_len,
	output logic [31:0]                   txn_id,
	output logic [31:0]                   seq_num,
	output logic [7:0]                    payload_byte,
	output logic [15:0]                   payload_index,
	output logic                          frame_end,
	output logic [31:0]                   error_count
);

	fpd_pkg::fpd_cfg_t    cfg_q;
	fpd_pkg::fpd_result_t core_result, out_data;
	logic                 valid_s1;
	logic [7:0]           rx_byte_s1;
	logic                 advance, fire;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first        <= 8'd0;
			cfg_q.sync_second       <= 8'd0;
			cfg_q.proto_ver         <= 8'd0;
			cfg_q.allowed_flag_mask <= 8'd0;
			cfg_q.max_body_len      <= 16'hFFFF;
		end else if (cfg_write) begin
			case (cfg_index)
				fpd_pkg::REG_SYNC_FIRST:  cfg_q.sync_first        <= cfg_data[7:0];
				fpd_pkg::REG_SYNC_SECOND: cfg_q.sync_second       <= cfg_data[7:0];
				fpd_pkg::REG_PROTO_VER:   cfg_q.proto_ver         <= cfg_data[7:0];
				fpd_pkg::REG_FLAG_MASK:   cfg_q.allowed_flag_mask <= cfg_data[7:0];
				fpd_pkg::REG_MAX_LEN:     cfg_q.max_body_len      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register: refills when empty or whenever its byte moves into the result register
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if ((!valid_s1 || advance) && in_valid) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	fpd_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.fire       (fire),
		.rx_byte_s1 (rx_byte_s1),
		.result     (core_result)
	);

	fpd_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load_data  (core_result),
		.load_ready (advance),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

	assign event_res     = out_data.event_res;
	assign msg_type      = out_data.msg_type;
	assign frame_flags   = out_data.frame_flags;
	assign body_len      = out_data.body_len;
	assign txn_id        = out_data.txn_id;
	assign seq_num       = out_data.seq_num;
	assign payload_byte  = out_data.payload_byte;
	assign payload_index = out_data.payload_index;
	assign frame_end     = out_data.frame_end;
	assign error_count   = out_data.error_count;

endmodule

[sv/fpd_checker.sv]
// Port-level checker for the deframer, bound to the top level.
module fpd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  event_res,
	input logic [7:0]  msg_type,
	input logic [7:0]  frame_flags,
	input logic [15:0] body_len,
	input logic [31:0] txn_id,
	input logic [31:0] seq_num,
	input logic [7:0]  payload_byte,
	input logic [15:0] payload_index,
	input logic        frame_end,
	input logic [31:0] error_count
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_res) &&
		$stable(error_count) && $stable(payload_index))
		else $error("result changed while stalled");

	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res != fpd_pkg::EV_PAYLOAD) |->
		payload_byte == 8'd0 && payload_index == 16'd0)
		else $error("payload fields set outside a payload byte");

	a_hdr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == fpd_pkg::EV_STORED || event_res == fpd_pkg::EV_REJECT) |->
		msg_type == 8'd0 && frame_flags == 8'd0 && body_len == 16'd0 &&
		txn_id == 32'd0 && seq_num == 32'd0 && !frame_end)
		else $error("header fields set before a header was decoded");

	a_end_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |->
		event_res == fpd_pkg::EV_PAYLOAD ||
		(event_res == fpd_pkg::EV_ACCEPT && body_len == 16'd0))
		else $error("frame end on a wrong event");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end && (event_res == fpd_pkg::EV_PAYLOAD) |->
		payload_index == body_len - 16'd1)
		else $error("frame end not on the last payload byte");

endmodule

bind framed_packet_deframer_top fpd_checker u_fpd_checker (.*);

[bench/framed_packet_deframer_top_tb.sv]
// Self-checking testbench for the framed packet deframer: random framed streams against a predictor.

// Tracks the deframer state, predicts one result per accepted byte and checks what comes out.
class deframer_scoreboard;
	fpd_pkg::fpd_cfg_t         cfg;
	logic [7:0]                hdr [fpd_pkg::HdrBytes];
	logic [fpd_pkg::FillW-1:0] fill;
	logic [15:0]               seen;
	logic [15:0]               plen;
	logic [31:0]               errs;
	fpd_pkg::fpd_result_t      expected_results [$];
	int unsigned               fails;
	int unsigned               bytes_noted;

	function new();
		cfg.sync_first        = 8'h00;
		cfg.sync_second       = 8'h00;
		cfg.proto_ver         = 8'h00;
		cfg.allowed_flag_mask = 8'h00;
		cfg.max_body_len      = 16'hFFFF;
		foreach (hdr[i])
			hdr[i] = 8'h00;
		fill        = '0;
		seen        = '0;
		plen        = '0;
		errs        = '0;
		fails       = 0;
		bytes_noted = 0;
	endfunction

	function void write_reg(logic [fpd_pkg::CfgIdxW-1:0] idx, logic [fpd_pkg::CfgDataW-1:0] data);
		case (idx)
			fpd_pkg::REG_SYNC_FIRST: cfg.sync_first        = data[7:0];
			fpd_pkg::REG_SYNC_SECOND: cfg.sync_second      = data[7:0];
			fpd_pkg::REG_PROTO_VER: cfg.proto_ver          = data[7:0];
			fpd_pkg::REG_FLAG_MASK: cfg.allowed_flag_mask  = data[7:0];
			fpd_pkg::REG_MAX_LEN: cfg.max_body_len         = data;
			default: ;
		endcase
	endfunction

	function void clear_frame();
		fill = '0;
		seen = '0;
		plen = '0;
	endfunction

	// One received byte in, one deframer result out.
	function fpd_pkg::fpd_result_t deframe(logic [7:0] b);
		fpd_pkg::fpd_result_t r;
		logic                 decoded;
		logic [15:0]          len;
		r           = '0;
		decoded     = 1'b0;
		r.event_res = fpd_pkg::EV_STORED;
		if (fill < fpd_pkg::FillW'(fpd_pkg::HdrBytes)) begin
			hdr[fill[fpd_pkg::HdrIdxW-1:0]] = b;
			fill = fill + 1'b1;
			if (fill == fpd_pkg::FillW'(fpd_pkg::HdrBytes)) begin
				if (hdr[0] != cfg.sync_first || hdr[1] != cfg.sync_second ||
						hdr[2] != cfg.proto_ver || hdr[5] != 8'(fpd_pkg::HdrBytes) ||
						(hdr[4] & ~cfg.allowed_flag_mask) != 8'h00) begin
					errs++;
					// a matching first byte is kept as the start of the next header
					fill        = (hdr[0] == cfg.sync_first) ? fpd_pkg::FillW'(1) : '0;
					r.event_res = fpd_pkg::EV_REJECT;
				end else begin
					len     = {hdr[7], hdr[6]};
					decoded = 1'b1;
					if (len > cfg.max_body_len) begin
						errs++;
						clear_frame();
						r.event_res = fpd_pkg::EV_TOO_LONG;
					end else begin
						r.event_res = fpd_pkg::EV_ACCEPT;
						plen        = len;
						seen        = '0;
						if (len == 16'h0000) begin
							r.frame_end = 1'b1;
							clear_frame();
						end
					end
				end
			end
		end else begin
			r.event_res     = fpd_pkg::EV_PAYLOAD;
			decoded         = 1'b1;
			r.payload_byte  = b;
			r.payload_index = seen;
			seen            = seen + 1'b1;
			if (seen == plen) begin
				r.frame_end = 1'b1;
				clear_frame();
			end
		end
		if (decoded) begin
			r.msg_type    = hdr[3];
			r.frame_flags = hdr[4];
			r.body_len    = {hdr[7], hdr[6]};
			r.txn_id      = {hdr[11], hdr[10], hdr[9], hdr[8]};
			r.seq_num     = {hdr[15], hdr[14], hdr[13], hdr[12]};
		end
		r.error_count = errs;
		return r;
	endfunction

	function void note_byte(logic [7:0] b);
		expected_results.push_back(deframe(b));
		bytes_noted++;
	endfunction

	function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fails++;
		end
	endfunction

	function void check(fpd_pkg::fpd_result_t got);
		fpd_pkg::fpd_result_t want;
		if (expected_results.size() == 0) begin
			$error("result with no pending expectation (event_res %0d)", got.event_res);
			fails++;
			return;
		end
		want = expected_results.pop_front();
		cmp_field("event_res", want.event_res, got.event_res);
		cmp_field("msg_type", want.msg_type, got.msg_type);
		cmp_field("frame_flags", want.frame_flags, got.frame_flags);
		cmp_field("body_len", want.body_len, got.body_len);
		cmp_field("txn_id", want.txn_id, got.txn_id);
		cmp_field("seq_num", want.seq_num, got.seq_num);
		cmp_field("payload_byte", want.payload_byte, got.payload_byte);
		cmp_field("payload_index", want.payload_index, got.payload_index);
		cmp_field("frame_end", want.frame_end, got.frame_end);
		cmp_field("error_count", want.error_count, got.error_count);
	endfunction
endclass

module framed_packet_deframer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit  = 500000;
	localparam int PhaseBytes  = 480;   // random bytes per configuration phase
	localparam int ShortLenCap = 20;    // usual payload length ceiling
	localparam int LongLenCap  = 300;   // occasional longer frame
	localparam int HoldAfter   = 300;   // bytes accepted before the long receiver hold-off
	localparam int HoldCycles  = 120;
	localparam int DrainCycles = 8;     // idle margin after the last expected result

	// shapes of stimulus frame
	typedef enum int {
		FK_GOOD,
		FK_LONG_GOOD,
		FK_EMPTY,
		FK_TOO_LONG,
		FK_BAD_SYNC0,
		FK_BAD_SYNC1,
		FK_BAD_VER,
		FK_BAD_HLEN,
		FK_BAD_FLAGS,
		FK_NOISE
	} frame_kind_t;

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_write;
	logic [fpd_pkg::CfgIdxW-1:0]  cfg_index;
	logic [fpd_pkg::CfgDataW-1:0] cfg_data;
	logic                         in_valid;
	logic                         in_stall;
	logic [7:0]                   rx_byte;
	logic                         out_valid;
	logic                         out_stall;
	logic [2:0]                   event_res;
	logic [7:0]                   msg_type;
	logic [7:0]                   frame_flags;
	logic [15:0]                  body_len;
	logic [31:0]                  txn_id;
	logic [31:0]                  seq_num;
	logic [7:0]                   payload_byte;
	logic [15:0]                  payload_index;
	logic                         frame_end;
	logic [31:0]                  error_count;

	deframer_scoreboard sb;
	int unsigned        cycles = 0;
	int                 burst_left;
	bit                 hold_done;

	framed_packet_deframer_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.event_res     (event_res),
		.msg_type      (msg_type),
		.frame_flags   (frame_flags),
		.body_len      (body_len),
		.txn_id        (txn_id),
		.seq_num       (seq_num),
		.payload_byte  (payload_byte),
		.payload_index (payload_index),
		.frame_end     (frame_end),
		.error_count   (error_count)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Output monitor: every result transaction goes to the scoreboard.
	always @(posedge clk) begin
		fpd_pkg::fpd_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.event_res     = fpd_pkg::fpd_event_t'(event_res);
			got.msg_type      = msg_type;
			got.frame_flags   = frame_flags;
			got.body_len      = body_len;
			got.txn_id        = txn_id;
			got.seq_num       = seq_num;
			got.payload_byte  = payload_byte;
			got.payload_index = payload_index;
			got.frame_end     = frame_end;
			got.error_count   = error_count;
			sb.check(got);
		end
	end

	// Receiver: segments of random stall density, plus one long hold-off while the
	// sender keeps offering, so the pipeline fills and in_stall must rise.
	initial begin : receiver
		int stall_pct;
		int seg;
		out_stall = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!hold_done && sb.bytes_noted > HoldAfter) begin
				hold_done = 1'b1;
				repeat (HoldCycles) begin
					@(negedge clk);
					out_stall <= 1'b1;
				end
			end else begin
				case ($urandom_range(0, 5))
					0, 1: stall_pct = 0;
					2: stall_pct = 20;
					3: stall_pct = 50;
					4: stall_pct = 80;
					default: stall_pct = 100;
				endcase
				seg = (stall_pct == 100) ? $urandom_range(5, 30) : $urandom_range(10, 150);
				repeat (seg) begin
					@(negedge clk);
					out_stall <= ($urandom_range(1, 100) <= stall_pct);
				end
			end
		end
	end

	// One input transaction. Bursts of random length, random gaps between them;
	// valid stays high across back-to-back bytes.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 9) == 0) begin
				burst_left = $urandom_range(100, 250);
				gap        = 0;
			end else begin
				burst_left = $urandom_range(1, 32);
				gap        = $urandom_range(0, 6);
			end
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		rx_byte  <= b;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_byte(b);
		burst_left--;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [fpd_pkg::CfgIdxW-1:0] idx,
			input logic [fpd_pkg::CfgDataW-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		sb.write_reg(idx, data);
	endtask

	// Writes all registers (junk in the unused upper byte of the 8-bit ones) and one random
	// index beyond the last register, which must be ignored.
	task automatic program_regs(input logic [7:0] s0, s1, ver, mask, input logic [15:0] maxlen);
		write_reg(fpd_pkg::REG_SYNC_FIRST, {8'($urandom), s0});
		write_reg(fpd_pkg::REG_SYNC_SECOND, {8'($urandom), s1});
		write_reg(fpd_pkg::REG_PROTO_VER, {8'($urandom), ver});
		write_reg(fpd_pkg::REG_FLAG_MASK, {8'($urandom), mask});
		write_reg(fpd_pkg::REG_MAX_LEN, maxlen);
		write_reg(fpd_pkg::CfgIdxW'($urandom_range(fpd_pkg::REG_MAX_LEN + 1,
			(1 << fpd_pkg::CfgIdxW) - 1)), fpd_pkg::CfgDataW'($urandom));
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	// Idle point: no more input, every expected result drained, latency margin.
	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (sb.expected_results.size() != 0)
			@(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	task automatic send_header(input logic [7:0] s0, s1, ver, mtype, flags, hlen,
			input logic [15:0] len, input logic [31:0] tid, seq, input bit skip_first);
		logic [7:0] hb [fpd_pkg::HdrBytes];
		hb[0]  = s0;
		hb[1]  = s1;
		hb[2]  = ver;
		hb[3]  = mtype;
		hb[4]  = flags;
		hb[5]  = hlen;
		hb[6]  = len[7:0];
		hb[7]  = len[15:8];
		hb[8]  = tid[7:0];
		hb[9]  = tid[15:8];
		hb[10] = tid[23:16];
		hb[11] = tid[31:24];
		hb[12] = seq[7:0];
		hb[13] = seq[15:8];
		hb[14] = seq[23:16];
		hb[15] = seq[31:24];
		// after a rejected header the kept sync byte already stands as byte 0
		for (int i = skip_first ? 1 : 0; i < fpd_pkg::HdrBytes; i++)
			send_byte(hb[i]);
	endtask

	function automatic logic [31:0] header_word();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic frame_kind_t pick_kind();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 45) return FK_GOOD;
		if (roll < 50) return FK_LONG_GOOD;
		if (roll < 58) return FK_EMPTY;
		if (roll < 66) return FK_TOO_LONG;
		if (roll < 71) return FK_BAD_SYNC0;
		if (roll < 75) return FK_BAD_SYNC1;
		if (roll < 79) return FK_BAD_VER;
		if (roll < 84) return FK_BAD_HLEN;
		if (roll < 90) return FK_BAD_FLAGS;
		return FK_NOISE;
	endfunction

	// Brings the stream back to a header boundary after noise or a misread frame:
	// finishes a running payload or pads out a partial header, until the deframer
	// is empty or holds only a kept sync byte.
	task automatic realign(output bit skip_first);
		while (!(sb.fill == '0 || (sb.fill == 1 && sb.hdr[0] == sb.cfg.sync_first))) begin
			if (sb.fill == fpd_pkg::FillW'(fpd_pkg::HdrBytes))
				repeat (sb.plen - sb.seen) send_byte(8'($urandom));
			else
				repeat (fpd_pkg::HdrBytes - sb.fill) send_byte(8'($urandom));
		end
		skip_first = (sb.fill == 1);
	endtask

	task automatic send_frame(input frame_kind_t kind, input bit skip_first);
		logic [7:0]  s0, s1, ver, flags, hlen, outside;
		logic [15:0] len, cap, maxlen;
		logic [31:0] tid, seq;
		int          n;
		s0      = sb.cfg.sync_first;
		s1      = sb.cfg.sync_second;
		ver     = sb.cfg.proto_ver;
		outside = ~sb.cfg.allowed_flag_mask;
		flags   = 8'($urandom) & sb.cfg.allowed_flag_mask;
		hlen    = 8'(fpd_pkg::HdrBytes);
		maxlen  = sb.cfg.max_body_len;
		tid     = header_word();
		seq     = header_word();
		// kinds this setting cannot produce fall back to a good frame
		if (kind == FK_TOO_LONG && maxlen == 16'hFFFF)
			kind = FK_GOOD;
		if (kind == FK_BAD_FLAGS && outside == 8'h00)
			kind = FK_GOOD;
		cap = (kind == FK_LONG_GOOD) ? 16'(LongLenCap) : 16'(ShortLenCap);
		if (cap > maxlen)
			cap = maxlen;
		len = 16'($urandom_range(0, cap));
		case (kind)
			FK_EMPTY: len = 16'h0000;
			FK_TOO_LONG: len = 16'($urandom_range(maxlen + 1, 16'hFFFF));
			FK_BAD_SYNC0: do s0 = 8'($urandom); while (s0 == sb.cfg.sync_first);
			FK_BAD_SYNC1: do s1 = 8'($urandom); while (s1 == sb.cfg.sync_second);
			FK_BAD_VER: do ver = 8'($urandom); while (ver == sb.cfg.proto_ver);
			FK_BAD_HLEN: do hlen = 8'($urandom); while (hlen == 8'(fpd_pkg::HdrBytes));
			FK_BAD_FLAGS: begin
				flags = flags | (8'($urandom) & outside);
				if ((flags & outside) == 8'h00)
					flags = flags | (outside & (~outside + 8'h01));
			end
			FK_NOISE: begin
				n = $urandom_range(1, 20);
				repeat (n) send_byte(8'($urandom));
				return;
			end
			default: ;
		endcase
		send_header(s0, s1, ver, 8'($urandom), flags, hlen, len, tid, seq, skip_first);
		if (kind == FK_GOOD || kind == FK_LONG_GOOD || kind == FK_EMPTY)
			repeat (len) send_byte(8'($urandom));
	endtask

	task automatic run_phase(input int budget);
		int unsigned start;
		bit          skip;
		start = sb.bytes_noted;
		while (sb.bytes_noted - start < budget) begin
			realign(skip);
			send_frame(pick_kind(), skip);
		end
	endtask

	initial begin : stimulus
		sb        = new();
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		rx_byte   = 8'h00;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		burst_left = 0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		program_regs(8'hA5, 8'h5A, 8'h01, 8'h0F, 16'd16);
		// directed: full header with extreme field values, two payload bytes 00 and FF
		send_header(sb.cfg.sync_first, sb.cfg.sync_second, sb.cfg.proto_ver, 8'hFF,
			sb.cfg.allowed_flag_mask, 8'(fpd_pkg::HdrBytes), 16'd2, 32'hFFFF_FFFF,
			32'h0000_0000, 1'b0);
		send_byte(8'h00);
		send_byte(8'hFF);
		run_phase(PhaseBytes);
		settle();

		// low extremes: every good frame must be empty
		program_regs(8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);
		run_phase(PhaseBytes);
		settle();

		// high extremes
		program_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
		run_phase(PhaseBytes);
		settle();

		program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			16'($urandom_range(0, 64)));
		run_phase(PhaseBytes);
		settle();

		if (sb.expected_results.size() != 0)
			$error("%0d expected results never arrived", sb.expected_results.size());
		if (sb.fails == 0 && sb.expected_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

[sim.f]
sv/fpd_pkg.sv
sv/fpd_core.sv
sv/fpd_out_reg.sv
sv/framed_packet_deframer_top.sv
sv/fpd_checker.sv
bench/framed_packet_deframer_top_tb.sv
